// File: design/deferred_packet_slot_table_top_assert.svh
// Assertion macros used by the checker of the slot table.
`ifndef DEFERRED_PACKET_SLOT_TABLE_TOP_ASSERT_SVH
`define DEFERRED_PACKET_SLOT_TABLE_TOP_ASSERT_SVH
// Implication checked on each rising clock edge outside reset.
`define DPST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DPST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: design/dpst_pkg.sv
// Package with shared types and constants of the deferred packet slot table.
`timescale 1ns / 1ps
`default_nettype none
package dpst_pkg;
  localparam int unsigned SLOTS_DEF = 24;
  localparam int unsigned PACKET_BYTES_DEF = 256;

  typedef enum logic [1:0] {
    REQ_DEFER = 2'd0,
    REQ_FLUSH = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_DEFER = 2'd0,
    KIND_FLUSH = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  typedef enum logic [1:0] {
    FILL_IDLE = 2'd0,
    FILL_BUSY = 2'd1,
    FILL_DROP = 2'd2
  } fill_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_SCAN  = 2'd1,
    BK_READ  = 2'd2,
    BK_LAST  = 2'd3
  } bk_state_t;

  // Queue entry from the front part to the back part.
  typedef struct packed {
    req_t        req;
    logic [7:0]  data;
    logic        last;
    logic [31:0] delay;
    logic [31:0] now;
    logic        ready;
    logic [4:0]  rslot;
    logic [7:0]  roff;
  } cmd_t;
endpackage
`default_nettype wire

// File: design/dpst_queue.sv
// Two-entry request queue between the front and the back part.
`timescale 1ns / 1ps
`default_nettype none
module dpst_queue
  import dpst_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  wire  rd_ready,
  output cmd_t rd_data
);
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Storage writes.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule
`default_nettype wire

// File: design/dpst_back.sv
// Back part: slot state, byte storage, flush scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module dpst_back
  import dpst_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF,
  parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_result_kind,
  output logic [1:0]  out_defer_status,
  output logic [4:0]  out_slot_index,
  output logic [8:0]  out_packet_length,
  output logic        out_was_sent,
  output logic [7:0]  out_read_byte,
  output logic        out_run_last
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int CW = $clog2(PACKET_BYTES + 2);
  localparam int DEPTH = SLOTS * PACKET_BYTES;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]    mem_r [DEPTH];
  logic [CW-1:0] len_r [SLOTS];
  logic [31:0]   due_r [SLOTS];
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [SW-1:0] fill_slot_r, fill_slot_nxt;
  logic [CW-1:0] fill_cnt_r, fill_cnt_nxt;
  fill_t         fill_r, fill_nxt;
  bk_state_t     st_r, st_nxt;
  logic [SW-1:0] scan_r, scan_nxt;
  logic [31:0]   snow_r, snow_nxt;
  logic          srdy_r, srdy_nxt;
  logic          pend_r, pend_nxt;
  logic [SW-1:0] pend_slot_r, pend_slot_nxt;
  logic [7:0]    rbyte_r;
  logic          rinr_r;
  // Result register.
  logic          ov_r, ov_nxt;
  logic [1:0]    ok_r, ok_nxt, ost_r, ost_nxt;
  logic [4:0]    osl_r, osl_nxt;
  logic [8:0]    olen_r, olen_nxt;
  logic          osent_r, osent_nxt, olast_r, olast_nxt;
  logic [7:0]    obyte_r, obyte_nxt;

  logic          out_free, mem_we, rd_go, due_hit;
  logic          slot_we;
  logic [SW-1:0] slot_we_idx;
  logic [CW-1:0] slot_we_len;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [SW-1:0] free_idx;
  logic          free_any;
  logic [31:0]   diff;

  assign out_free = !ov_r || out_ready;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = SW'(i);
        free_any = 1'b1;
      end
    end
  end

  assign diff    = snow_r - due_r[scan_r];
  assign due_hit = used_r[scan_r] && !diff[31];

  always_comb begin
    st_nxt = st_r; scan_nxt = scan_r; snow_nxt = snow_r; srdy_nxt = srdy_r;
    pend_nxt = pend_r; pend_slot_nxt = pend_slot_r;
    used_nxt = used_r; fill_slot_nxt = fill_slot_r; fill_cnt_nxt = fill_cnt_r;
    fill_nxt = fill_r;
    ov_nxt = ov_r && !out_ready; ok_nxt = ok_r; ost_nxt = ost_r; osl_nxt = osl_r;
    olen_nxt = olen_r; osent_nxt = osent_r; olast_nxt = olast_r; obyte_nxt = obyte_r;
    cmd_ready = 1'b0; mem_we = 1'b0; mem_wa = '0; rd_go = 1'b0;
    slot_we = 1'b0; slot_we_idx = '0; slot_we_len = '0;
    unique case (st_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.req)
            REQ_DEFER: begin
              logic [SW-1:0] fs;
              fill_t fst;
              logic [CW-1:0] fc;
              logic [1:0] status;
              fs = fill_slot_r; fst = fill_r; fc = fill_cnt_r;
              if (fill_r == FILL_IDLE) begin
                fst = free_any ? FILL_BUSY : FILL_DROP;
                fs  = free_any ? free_idx : '0;
                fc  = '0;
              end
              status = ST_ACCEPTED;
              if (!cmd.last || out_free) begin
                cmd_ready = 1'b1;
                if (fc < CW'(PACKET_BYTES)) begin
                  if (fst == FILL_BUSY) begin
                    mem_we = 1'b1;
                    mem_wa = AW'(fs) * AW'(PACKET_BYTES) + AW'(fc);
                  end
                  fc = fc + 1'b1;
                end else begin
                  fc = CW'(PACKET_BYTES + 1);
                end
                fill_slot_nxt = fs; fill_nxt = fst; fill_cnt_nxt = fc;
                if (cmd.last) begin
                  if (fc > CW'(PACKET_BYTES)) status = ST_TOO_LONG;
                  else if (fst != FILL_BUSY) status = ST_NO_SLOT;
                  if (status == ST_ACCEPTED) begin
                    used_nxt[fs] = 1'b1;
                    slot_we = 1'b1; slot_we_idx = fs; slot_we_len = fc;
                  end
                  ov_nxt = 1'b1; ok_nxt = KIND_DEFER; ost_nxt = status;
                  osl_nxt = (status == ST_ACCEPTED) ? 5'(fs) : 5'd0;
                  olen_nxt = '0; osent_nxt = 1'b0; obyte_nxt = '0; olast_nxt = 1'b1;
                  fill_nxt = FILL_IDLE; fill_cnt_nxt = '0; fill_slot_nxt = '0;
                end
              end
            end
            REQ_FLUSH: begin
              cmd_ready = 1'b1;
              st_nxt = BK_SCAN; scan_nxt = '0; snow_nxt = cmd.now;
              srdy_nxt = cmd.ready; pend_nxt = 1'b0;
            end
            REQ_READ: begin
              cmd_ready = 1'b1; rd_go = 1'b1; st_nxt = BK_READ;
            end
            default: cmd_ready = 1'b1;
          endcase
        end
      end
      BK_SCAN: begin
        // One slot per cycle unless stalled; a hit waits till last is known.
        if (!pend_r || out_free) begin
          if (pend_r && (due_hit || scan_r == SW'(SLOTS - 1))) begin
            ov_nxt = 1'b1; ok_nxt = KIND_FLUSH; ost_nxt = '0;
            osl_nxt = 5'(pend_slot_r); olen_nxt = 9'(len_r[pend_slot_r]);
            osent_nxt = srdy_r; obyte_nxt = '0;
            olast_nxt = !(due_hit && scan_r != SW'(SLOTS - 1)) && !due_hit;
            pend_nxt = 1'b0;
          end
          if (due_hit) begin
            used_nxt[scan_r] = 1'b0;
            pend_nxt = 1'b1; pend_slot_nxt = scan_r;
          end
          if (scan_r == SW'(SLOTS - 1)) begin
            if (!due_hit) st_nxt = BK_IDLE;
            else scan_nxt = scan_r;
          end else begin
            scan_nxt = scan_r + 1'b1;
          end
          if (scan_r == SW'(SLOTS - 1) && due_hit) st_nxt = BK_LAST;
        end
      end
      BK_READ: begin
        if (out_free) begin
          ov_nxt = 1'b1; ok_nxt = KIND_READ; ost_nxt = '0; osl_nxt = '0;
          olen_nxt = '0; osent_nxt = 1'b0; obyte_nxt = rinr_r ? rbyte_r : 8'd0;
          olast_nxt = 1'b1; st_nxt = BK_IDLE;
        end
      end
      BK_LAST: begin
        // Final held flush report after the last slot.
        if (out_free) begin
          ov_nxt = 1'b1; ok_nxt = KIND_FLUSH; ost_nxt = '0;
          osl_nxt = 5'(pend_slot_r); olen_nxt = 9'(len_r[pend_slot_r]);
          osent_nxt = srdy_r; obyte_nxt = '0; olast_nxt = 1'b1;
          pend_nxt = 1'b0; st_nxt = BK_IDLE;
        end
      end
    endcase
  end

  assign mem_ra = AW'(cmd.rslot[SW-1:0]) * AW'(PACKET_BYTES) + AW'(cmd.roff[BW-1:0]);

  // Byte storage, written and read in one clocked block.
  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= cmd.data;
    if (rd_go) begin
      rbyte_r <= mem_r[mem_ra];
      rinr_r  <= (32'(cmd.rslot) < SLOTS) && (32'(cmd.roff) < PACKET_BYTES);
    end
  end

  // Per-slot length and due time at the accepted last byte.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      len_r[slot_we_idx] <= slot_we_len;
      due_r[slot_we_idx] <= cmd.now + cmd.delay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; used_r <= '0; fill_r <= FILL_IDLE; fill_slot_r <= '0;
      fill_cnt_r <= '0; pend_r <= 1'b0; ov_r <= 1'b0;
      scan_r <= '0;
    end else begin
      st_r <= st_nxt; used_r <= used_nxt; fill_r <= fill_nxt;
      fill_slot_r <= fill_slot_nxt; fill_cnt_r <= fill_cnt_nxt; pend_r <= pend_nxt;
      ov_r <= ov_nxt; scan_r <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snow_r <= snow_nxt; srdy_r <= srdy_nxt; pend_slot_r <= pend_slot_nxt;
    ok_r <= ok_nxt; ost_r <= ost_nxt; osl_r <= osl_nxt; olen_r <= olen_nxt;
    osent_r <= osent_nxt; olast_r <= olast_nxt; obyte_r <= obyte_nxt;
  end

  assign out_valid = ov_r;
  assign out_result_kind = ok_r;
  assign out_defer_status = ost_r;
  assign out_slot_index = osl_r;
  assign out_packet_length = olen_r;
  assign out_was_sent = osent_r;
  assign out_read_byte = obyte_r;
  assign out_run_last = olast_r;
endmodule
`default_nettype wire

// File: design/deferred_packet_slot_table_top.sv
// Top level of the deferred packet slot table.
// Requests enter a two-entry registered queue before they reach the back
// part; the back part holds slot state and byte storage and works on one
// request at a time. A last defer byte puts its status in the result
// register when taken; a read first does a registered memory read and
// then loads the result; a flush latches its time, then scans one slot
// per cycle while no held hit waits on the result register, with a final
// report state when the last slot is due. A held result that out_ready
// does not take stalls the back part, and a full queue then drops in_ready.
// Byte storage needs no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module deferred_packet_slot_table_top
  import dpst_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF,
  parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_req_type,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_byte_last,
  input  wire  [31:0] in_delay_ms,
  input  wire  [31:0] in_now_ms,
  input  wire         in_radio_ready,
  input  wire  [4:0]  in_read_slot,
  input  wire  [7:0]  in_read_offset,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_result_kind,
  output logic [1:0]  out_defer_status,
  output logic [4:0]  out_slot_index,
  output logic [8:0]  out_packet_length,
  output logic        out_was_sent,
  output logic [7:0]  out_read_byte,
  output logic        out_run_last
);
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;

  // Front part: classify and pack the request.
  always_comb begin
    in_cmd.req   = req_t'(in_req_type);
    in_cmd.data  = in_data_byte;
    in_cmd.last  = in_byte_last;
    in_cmd.delay = in_delay_ms;
    in_cmd.now   = in_now_ms;
    in_cmd.ready = in_radio_ready;
    in_cmd.rslot = in_read_slot;
    in_cmd.roff  = in_read_offset;
  end

  dpst_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(in_valid), .wr_ready(in_ready),
    .wr_data(in_cmd), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  dpst_back #(.SLOTS(SLOTS), .PACKET_BYTES(PACKET_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_kind(out_result_kind),
    .out_defer_status(out_defer_status), .out_slot_index(out_slot_index),
    .out_packet_length(out_packet_length), .out_was_sent(out_was_sent),
    .out_read_byte(out_read_byte), .out_run_last(out_run_last)
  );
endmodule
`default_nettype wire

// File: design/dpst_checker.sv
// Port-level checker for the deferred packet slot table, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
`include "deferred_packet_slot_table_top_assert.svh"
module dpst_checker
  import dpst_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [1:0] out_result_kind,
  input wire [1:0] out_defer_status,
  input wire [4:0] out_slot_index,
  input wire       out_run_last
);
  // A stalled result keeps its kind.
  `DPST_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, $stable(out_result_kind))
  // Reads and defer reports always close their request.
  `DPST_ASSERT_IMPL(a_last, clk, rst_n, out_valid && out_result_kind != KIND_FLUSH, out_run_last)
  // A rejected defer reports slot zero.
  `DPST_ASSERT_IMPL(a_rej, clk, rst_n,
    out_valid && out_result_kind == KIND_DEFER && out_defer_status != ST_ACCEPTED, out_slot_index == 5'd0)
endmodule
bind deferred_packet_slot_table_top dpst_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_result_kind(out_result_kind), .out_defer_status(out_defer_status),
  .out_slot_index(out_slot_index), .out_run_last(out_run_last)
);
`default_nettype wire

// File: bench/tb_deferred_packet_slot_table_top.sv
// Self-checking testbench for the deferred packet slot table top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_deferred_packet_slot_table_top;
  import dpst_pkg::*;

  localparam int NSLOT = 24;
  localparam int NBYTE = 256;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_req_type = REQ_NONE;
  logic [7:0] in_data_byte = '0;
  logic in_byte_last = 1'b0;
  logic [31:0] in_delay_ms = '0;
  logic [31:0] in_now_ms = '0;
  logic in_radio_ready = 1'b0;
  logic [4:0] in_read_slot = '0;
  logic [7:0] in_read_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_result_kind;
  logic [1:0] out_defer_status;
  logic [4:0] out_slot_index;
  logic [8:0] out_packet_length;
  logic out_was_sent;
  logic [7:0] out_read_byte;
  logic out_run_last;

  deferred_packet_slot_table_top dut (.*);

  always #6 clk = ~clk;

  // One request and one result.
  typedef struct packed {
    logic [1:0] req;
    logic [7:0] data;
    logic last;
    logic [31:0] delay;
    logic [31:0] now;
    logic ready;
    logic [4:0] rslot;
    logic [7:0] roff;
  } request_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic [4:0] slot;
    logic [8:0] len;
    logic sent;
    logic [7:0] rbyte;
    logic last;
  } result_t;

  // Predictor state.
  logic [7:0] bytes_mem [NSLOT*NBYTE];
  logic [8:0] len_mem [NSLOT];
  logic [31:0] due_mem [NSLOT];
  logic used_mem [NSLOT];
  logic written [NSLOT*NBYTE];
  fill_t fstate;
  int fslot, fcount;

  result_t results_due[$];
  int errors = 0;
  int cycles = 0;
  logic [31:0] clock_ms = 32'd1000;

  // Works out the results of one request and queues them.
  function automatic void predict_request(request_t r);
    int n;
    logic [1:0] st;
    result_t row;
    n = 0;
    row = '0;
    if (r.req == REQ_DEFER) begin
      if (fstate == FILL_IDLE) begin
        fstate = FILL_DROP;
        fslot = 0;
        for (int i = 0; i < NSLOT; i++)
          if (!used_mem[i]) begin
            fslot = i;
            fstate = FILL_BUSY;
            break;
          end
        fcount = 0;
      end
      if (fcount < NBYTE) begin
        if (fstate == FILL_BUSY) begin
          bytes_mem[fslot*NBYTE+fcount] = r.data;
          written[fslot*NBYTE+fcount] = 1'b1;
        end
        fcount++;
      end else begin
        fcount = NBYTE + 1;
      end
      if (r.last) begin
        if (fcount > NBYTE) st = ST_TOO_LONG;
        else if (fstate != FILL_BUSY) st = ST_NO_SLOT;
        else st = ST_ACCEPTED;
        if (st == ST_ACCEPTED) begin
          len_mem[fslot] = fcount[8:0];
          due_mem[fslot] = r.now + r.delay;
          used_mem[fslot] = 1'b1;
          row.slot = fslot[4:0];
        end
        row.kind = KIND_DEFER;
        row.status = st;
        row.last = 1'b1;
        results_due.push_back(row);
        fstate = FILL_IDLE;
        fcount = 0;
        fslot = 0;
      end
    end else if (r.req == REQ_FLUSH) begin
      for (int i = 0; i < NSLOT; i++) begin
        if (!used_mem[i] || (fstate == FILL_BUSY && fslot == i)) continue;
        if ((r.now - due_mem[i]) >> 31) continue;
        used_mem[i] = 1'b0;
        row = '0;
        row.kind = KIND_FLUSH;
        row.slot = i[4:0];
        row.len = len_mem[i];
        row.sent = r.ready;
        results_due.push_back(row);
        n++;
      end
      if (n > 0) results_due[results_due.size()-1].last = 1'b1;
    end else if (r.req == REQ_READ) begin
      row.kind = KIND_READ;
      if (r.rslot < NSLOT) row.rbyte = bytes_mem[r.rslot*NBYTE + r.roff];
      row.last = 1'b1;
      results_due.push_back(row);
    end
  endfunction

  // Sends one request and predicts its results at acceptance.
  task automatic send_request(request_t r);
    in_valid <= 1'b1;
    in_req_type <= r.req;
    in_data_byte <= r.data;
    in_byte_last <= r.last;
    in_delay_ms <= r.delay;
    in_now_ms <= r.now;
    in_radio_ready <= r.ready;
    in_read_slot <= r.rslot;
    in_read_offset <= r.roff;
    do @(posedge clk); while (!in_ready);
    predict_request(r);
  endtask

  // Random gap between bursts.
  int burst_left = 0;
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_paced(request_t r);
    pace();
    send_request(r);
  endtask

  function automatic request_t make_byte(logic [7:0] d, logic l, logic [31:0] dl,
                                         logic [31:0] nw);
    request_t r;
    r = '0;
    r.req = REQ_DEFER;
    r.data = d;
    r.last = l;
    r.delay = dl;
    r.now = nw;
    return r;
  endfunction

  // Read only of bytes known to be written, or out-of-range slots.
  function automatic request_t make_read();
    request_t r;
    int s, o;
    r = '0;
    r.req = REQ_READ;
    r.data = $urandom;
    r.now = $urandom;
    if ($urandom_range(0, 7) == 0) begin
      r.rslot = $urandom_range(NSLOT, 31);
      r.roff = $urandom;
      return r;
    end
    for (int t = 0; t < 50; t++) begin
      s = $urandom_range(0, NSLOT - 1);
      o = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 7);
      if (written[s*NBYTE+o]) begin
        r.rslot = s;
        r.roff = o;
        return r;
      end
    end
    r.rslot = 31;
    r.roff = 8'hff;
    return r;
  endfunction

  // Packet of random bytes at the given length, with random reads mixed in.
  task automatic send_packet(int len, logic [31:0] dl);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 15) == 0) send_paced(make_read());
      send_paced(make_byte($urandom_range(0, 255), k == len - 1, dl, clock_ms));
    end
  endtask

  function automatic request_t make_flush(logic [31:0] nw, logic rd);
    request_t r;
    r = '0;
    r.req = REQ_FLUSH;
    r.now = nw;
    r.ready = rd;
    r.delay = $urandom;
    return r;
  endfunction

  // Directed table: request plus an optional typed-in expected first result.
  typedef struct packed {
    request_t rq;
    logic has_fixed;
    result_t fixed;
  } step_t;
  step_t steps[$];

  function automatic result_t defer_row(logic [1:0] st, logic [4:0] sl);
    result_t x;
    x = '0;
    x.kind = KIND_DEFER;
    x.status = st;
    x.slot = sl;
    x.last = 1'b1;
    return x;
  endfunction

  // Result checking and receiver stalls.
  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        result_t got, want;
        got = {out_result_kind, out_defer_status, out_slot_index, out_packet_length,
               out_was_sent, out_read_byte, out_run_last};
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
      out_ready <= (cycles % 64 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    request_t r;
    int drain;
    fstate = FILL_IDLE;
    fslot = 0;
    fcount = 0;
    for (int i = 0; i < NSLOT; i++) begin
      used_mem[i] = 1'b0;
      len_mem[i] = '0;
      due_mem[i] = '0;
    end
    for (int i = 0; i < NSLOT*NBYTE; i++) begin
      bytes_mem[i] = '0;
      written[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one-byte packet into slot 0, read it back, an idle request,
    // empty flush, interleaved flush and read during a fill, flushes that
    // drop and send, wrap-around due time, and an oversize packet.
    steps.push_back('{make_byte(8'hff, 1'b1, 32'd0, 32'hffff_fff0), 1'b1,
                      defer_row(ST_ACCEPTED, 5'd0)});
    r = '0; r.req = REQ_READ; r.rslot = 0; r.roff = 0;
    steps.push_back('{r, 1'b0, '0});
    r = '1; r.req = REQ_NONE;
    steps.push_back('{r, 1'b0, '0});
    r = '0; r.req = REQ_READ; r.rslot = 5'd31; r.roff = 8'hff;
    steps.push_back('{r, 1'b1, '{KIND_READ, 2'd0, 5'd0, 9'd0, 1'b0, 8'd0, 1'b1}});
    steps.push_back('{make_flush(32'hffff_ffe0, 1'b1), 1'b0, '0});
    steps.push_back('{make_byte(8'h00, 1'b0, 32'hffff_ffff, 32'd0), 1'b0, '0});
    steps.push_back('{make_flush(32'h0000_0010, 1'b0), 1'b0, '0});
    r = '0; r.req = REQ_READ; r.rslot = 1; r.roff = 0;
    steps.push_back('{r, 1'b0, '0});
    steps.push_back('{make_byte(8'haa, 1'b1, 32'h0000_0020, 32'hffff_fff0), 1'b1,
                      defer_row(ST_ACCEPTED, 5'd1)});
    steps.push_back('{make_flush(32'h0000_0010, 1'b1), 1'b0, '0});
    steps.push_back('{make_flush(32'h7fff_ffff, 1'b1), 1'b0, '0});
    foreach (steps[i]) begin
      int base;
      base = results_due.size();
      send_request(steps[i].rq);
      if (steps[i].has_fixed && results_due.size() > base &&
          results_due[base] !== steps[i].fixed) begin
        $display("%0t: mismatch expected %h actual %h", $time, steps[i].fixed,
                 results_due[base]);
        errors++;
      end
    end
    // Oversize packet of 257 bytes.
    for (int k = 0; k < 257; k++)
      send_request(make_byte($urandom, k == 256, 32'd5, clock_ms));
    // Full 256-byte packet.
    send_packet(256, 32'd0);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);

    // Fill every slot, then overflow with no free slot.
    for (int p = 0; p < NSLOT + 2; p++)
      send_packet($urandom_range(1, 6), $urandom_range(0, 100));
    send_paced(make_flush(clock_ms + 32'd200, $urandom_range(0, 1)));

    // Random part.
    for (int n = 0; n < 40; n++) begin
      clock_ms += $urandom_range(0, 40);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_packet($urandom_range(1, 8),
                                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 80));
        4, 5: send_paced(make_flush($urandom_range(0, 7) == 0 ? $urandom : clock_ms,
                                    $urandom_range(0, 1)));
        6, 7: send_paced(make_read());
        8: begin
          r = '0;
          r.req = REQ_NONE;
          r.data = $urandom;
          r.now = $urandom;
          send_paced(r);
        end
        default: begin
          // Broken packet: a flush lands in the middle of a fill.
          send_paced(make_byte($urandom, 1'b0, $urandom, clock_ms));
          send_paced(make_flush(clock_ms, $urandom_range(0, 1)));
          send_paced(make_byte($urandom, 1'b1, $urandom_range(0, 50), clock_ms));
        end
      endcase
      if (n == 20) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    drain = 0;
    while (results_due.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (60) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: deferred_packet_slot_table_top.f
+incdir+design
design/dpst_pkg.sv
design/dpst_queue.sv
design/dpst_back.sv
design/deferred_packet_slot_table_top.sv
design/dpst_checker.sv
bench/tb_deferred_packet_slot_table_top.sv
